// File: rtl/core/qau_pkg.sv
`default_nettype none
package qau_pkg;

    localparam int CW        = 32;
    localparam int FB        = 28;
    localparam int MW        = 2 * CW + 2;
    localparam int N2W       = 2 * CW + 1;
    localparam int DN2W      = 2 * (CW + 1) + 2;
    localparam int SQW       = N2W / 2 + 1;
    localparam int SRW       = N2W + 1;
    localparam int SQ_STAGES = SQW;
    localparam int QW        = CW;
    localparam int DW        = N2W + 1;
    localparam int NW        = CW + 2 * FB + 2;
    localparam int RW        = DW + QW;
    localparam int TW        = CW - 1;

    localparam logic [2:0] KIND_MUL    = 3'd0;
    localparam logic [2:0] KIND_CONJ   = 3'd1;
    localparam logic [2:0] KIND_INV    = 3'd2;
    localparam logic [2:0] KIND_NORM   = 3'd3;
    localparam logic [2:0] KIND_UNIT   = 3'd4;
    localparam logic [2:0] KIND_APPROX = 3'd5;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam logic [1:0] CFG_UNIT_TOL   = 2'd0;
    localparam logic [1:0] CFG_APPROX_TOL = 2'd1;
    localparam logic [1:0] CFG_MIN_NORM   = 2'd2;

    typedef struct packed {
        logic [2:0]             kind;
        logic                   zero;
        logic                   test;
        logic                   sat;
        logic [3:0][CW-1:0]     res;
        logic [3:0]             neg;
        logic [3:0][CW-1:0]     mag;
        logic [N2W-1:0]         n2;
    } t_side;

endpackage
`default_nettype wire

// File: rtl/core/quaternion_arith_unit.sv
// quaternion arithmetic unit, signed Q3.28 coefficients
// input channel: i_in_valid / o_in_ready carries i_kind and quaternions a and b;
// one beat is taken at each edge where both are high
// output channel: o_out_valid / i_out_ready carries r, o_test_true, o_status
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data,
// always ready; index 0 unit tolerance, 1 approx tolerance, 2 min norm,
// index 3 is ignored; write only while no beat is in flight
// every kind takes the same path: 72 cycles from input beat to output valid,
// set by the 33-stage square root pipeline and the 33-stage divider
// throughput is one beat per cycle; results leave in input order
// when the receiver stalls with a result waiting the whole pipeline holds,
// o_in_ready drops, and nothing is lost or repeated
// reset clears all valid bits and loads the register defaults
// (268, 268, 1); no clearing pass is needed
`default_nettype none
module quaternion_arith_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [2:0]                     i_kind,
    input  wire logic signed [qau_pkg::CW-1:0]  i_a_scalar,
    input  wire logic signed [qau_pkg::CW-1:0]  i_a_x,
    input  wire logic signed [qau_pkg::CW-1:0]  i_a_y,
    input  wire logic signed [qau_pkg::CW-1:0]  i_a_z,
    input  wire logic signed [qau_pkg::CW-1:0]  i_b_scalar,
    input  wire logic signed [qau_pkg::CW-1:0]  i_b_x,
    input  wire logic signed [qau_pkg::CW-1:0]  i_b_y,
    input  wire logic signed [qau_pkg::CW-1:0]  i_b_z,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [qau_pkg::CW-1:0]       o_r_scalar,
    output logic signed [qau_pkg::CW-1:0]       o_r_x,
    output logic signed [qau_pkg::CW-1:0]       o_r_y,
    output logic signed [qau_pkg::CW-1:0]       o_r_z,
    output logic                                o_test_true,
    output logic [1:0]                          o_status,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [qau_pkg::TW-1:0]         i_cfg_data
);

    localparam int CW   = qau_pkg::CW;
    localparam int FB   = qau_pkg::FB;
    localparam int MW   = qau_pkg::MW;
    localparam int N2W  = qau_pkg::N2W;
    localparam int DN2W = qau_pkg::DN2W;
    localparam int TW   = qau_pkg::TW;
    localparam int NW   = qau_pkg::NW;
    localparam int DW   = qau_pkg::DW;

    localparam logic [CW-1:0] ONE  = CW'(1) << FB;
    localparam logic [MW-1:0] HALF = MW'(1) << (CW - 1);
    localparam logic [MW-1:0] RND  = MW'(1) << (FB - 1);
    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [CW-1:0] val;
        logic          sat;
    } t_enc;

    function automatic t_enc f_encode(input logic neg, input logic [MW-1:0] mag);
        t_enc e;
        e.sat = 1'b0;
        if (!neg) begin
            if (mag >= HALF) begin
                e.val = MAXV;
                e.sat = 1'b1;
            end else begin
                e.val = mag[CW-1:0];
            end
        end else begin
            if (mag > HALF) begin
                e.val = MINV;
                e.sat = 1'b1;
            end else begin
                e.val = ~mag[CW-1:0] + 1'b1;
            end
        end
        return e;
    endfunction

    logic en;

    // config registers
    logic [TW-1:0] r_unit_tol, r_apx_tol, r_min_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_tol <= TW'(268);
            r_apx_tol  <= TW'(268);
            r_min_norm <= TW'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qau_pkg::CFG_UNIT_TOL:   r_unit_tol <= i_cfg_data;
                qau_pkg::CFG_APPROX_TOL: r_apx_tol  <= i_cfg_data;
                qau_pkg::CFG_MIN_NORM:   r_min_norm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // stage 0: capture
    logic                 r0_vld;
    logic [2:0]           r0_kind;
    logic signed [CW-1:0] r0_a [4];
    logic signed [CW-1:0] r0_b [4];
    logic signed [CW:0]   r0_d [4];
    logic [CW-1:0]        r0_lo, r0_hi;
    logic [TW-1:0]        r0_mn, r0_atol;

    logic signed [CW-1:0] in_a [4];
    logic signed [CW-1:0] in_b [4];
    logic [CW-1:0]        n0_lo;

    always_comb begin
        in_a[0] = i_a_scalar;
        in_a[1] = i_a_x;
        in_a[2] = i_a_y;
        in_a[3] = i_a_z;
        in_b[0] = i_b_scalar;
        in_b[1] = i_b_x;
        in_b[2] = i_b_y;
        in_b[3] = i_b_z;
        if (ONE > CW'(r_unit_tol)) begin
            n0_lo = ONE - CW'(r_unit_tol);
        end else begin
            n0_lo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_kind <= i_kind;
            for (int i = 0; i < 4; i++) begin
                r0_a[i] <= in_a[i];
                r0_b[i] <= in_b[i];
                r0_d[i] <= (CW+1)'(in_a[i]) - (CW+1)'(in_b[i]);
            end
            r0_lo   <= n0_lo;
            r0_hi   <= ONE + CW'(r_unit_tol);
            r0_mn   <= r_min_norm;
            r0_atol <= r_apx_tol;
        end
    end

    // stage 1: products
    logic                     r1_vld;
    logic [2:0]               r1_kind;
    logic signed [CW-1:0]     r1_a [4];
    logic signed [2*CW-1:0]   r1_p [4][4];
    logic [2*CW-1:0]          r1_sq [4];
    logic signed [2*CW+1:0]   r1_dd [4];
    logic [2*TW-1:0]          r1_mn2, r1_tol2;
    logic [2*CW-1:0]          r1_lo2, r1_hi2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= r0_kind;
            for (int i = 0; i < 4; i++) begin
                r1_a[i]  <= r0_a[i];
                r1_sq[i] <= r0_a[i] * r0_a[i];
                r1_dd[i] <= r0_d[i] * r0_d[i];
                for (int j = 0; j < 4; j++) begin
                    r1_p[i][j] <= r0_a[i] * r0_b[j];
                end
            end
            r1_mn2  <= r0_mn * r0_mn;
            r1_tol2 <= r0_atol * r0_atol;
            r1_lo2  <= r0_lo * r0_lo;
            r1_hi2  <= r0_hi * r0_hi;
        end
    end

    // stage 2: sums
    logic                 r2_vld;
    logic [2:0]           r2_kind;
    logic signed [CW-1:0] r2_a [4];
    logic signed [MW-1:0] r2_m [4];
    logic [N2W-1:0]       r2_n2;
    logic [DN2W-1:0]      r2_dn2;
    logic [2*TW-1:0]      r2_mn2, r2_tol2;
    logic [2*CW-1:0]      r2_lo2, r2_hi2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_kind <= r1_kind;
            for (int i = 0; i < 4; i++) begin
                r2_a[i] <= r1_a[i];
            end
            r2_m[0] <= MW'(r1_p[0][0]) - MW'(r1_p[1][1])
                     - MW'(r1_p[2][2]) - MW'(r1_p[3][3]);
            r2_m[1] <= MW'(r1_p[0][1]) + MW'(r1_p[1][0])
                     + MW'(r1_p[2][3]) - MW'(r1_p[3][2]);
            r2_m[2] <= MW'(r1_p[0][2]) - MW'(r1_p[1][3])
                     + MW'(r1_p[2][0]) + MW'(r1_p[3][1]);
            r2_m[3] <= MW'(r1_p[0][3]) + MW'(r1_p[1][2])
                     - MW'(r1_p[2][1]) + MW'(r1_p[3][0]);
            r2_n2   <= N2W'(r1_sq[0]) + N2W'(r1_sq[1]) + N2W'(r1_sq[2]) + N2W'(r1_sq[3]);
            r2_dn2  <= DN2W'(unsigned'(r1_dd[0])) + DN2W'(unsigned'(r1_dd[1]))
                     + DN2W'(unsigned'(r1_dd[2])) + DN2W'(unsigned'(r1_dd[3]));
            r2_mn2  <= r1_mn2;
            r2_tol2 <= r1_tol2;
            r2_lo2  <= r1_lo2;
            r2_hi2  <= r1_hi2;
        end
    end

    // stage 3: rounding, tests, side data
    logic           r3_vld;
    qau_pkg::t_side r3_side;
    qau_pkg::t_side n3_side;

    always_comb begin
        logic [MW-1:0] mag;
        logic [MW-1:0] rm;
        logic          unit_ok;
        logic          apx_ok;
        t_enc          e;
        n3_side      = '0;
        n3_side.kind = r2_kind;
        n3_side.n2   = r2_n2;
        mag          = '0;
        rm           = '0;
        e            = '0;
        unit_ok = (r2_n2 >= N2W'(r2_lo2)) && (r2_n2 <= N2W'(r2_hi2));
        apx_ok  = r2_dn2 <= DN2W'(r2_tol2);
        for (int i = 0; i < 4; i++) begin
            n3_side.neg[i] = r2_a[i][CW-1];
            n3_side.mag[i] = r2_a[i][CW-1] ? (~r2_a[i] + 1'b1) : r2_a[i];
        end
        unique case (r2_kind)
            qau_pkg::KIND_MUL: begin
                for (int i = 0; i < 4; i++) begin
                    mag = r2_m[i][MW-1] ? (~r2_m[i] + 1'b1) : r2_m[i];
                    rm  = (mag + RND) >> FB;
                    e   = f_encode(r2_m[i][MW-1], rm);
                    n3_side.res[i] = e.val;
                    n3_side.sat    = n3_side.sat | e.sat;
                end
            end
            qau_pkg::KIND_CONJ: begin
                n3_side.res[0] = r2_a[0];
                for (int i = 1; i < 4; i++) begin
                    e = f_encode(!r2_a[i][CW-1], MW'(n3_side.mag[i]));
                    n3_side.res[i] = e.val;
                    n3_side.sat    = n3_side.sat | e.sat;
                end
            end
            qau_pkg::KIND_INV, qau_pkg::KIND_NORM: begin
                n3_side.zero = (r2_n2 < N2W'(r2_mn2)) || (r2_n2 == '0);
            end
            qau_pkg::KIND_UNIT:   n3_side.test = unit_ok;
            qau_pkg::KIND_APPROX: n3_side.test = apx_ok;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side <= n3_side;
        end
    end

    // square root of the squared norm
    logic                     sq_vld;
    qau_pkg::t_side           sq_side;
    logic [qau_pkg::SQW-1:0]  sq_root;

    qau_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_side  (r3_side),
        .o_vld   (sq_vld),
        .o_side  (sq_side),
        .o_root  (sq_root)
    );

    // stage 4: divider operands, round to nearest via (2n + d) / 2d
    logic                 r4_vld;
    qau_pkg::t_side       r4_side;
    logic [3:0][NW-1:0]   r4_num;
    logic [DW-1:0]        r4_den;

    always_ff @(posedge i_clk) begin
        logic [N2W-1:0] den;
        logic [NW-1:0]  num;
        if (en) begin
            if (sq_side.kind == qau_pkg::KIND_INV) begin
                den = sq_side.n2;
            end else begin
                den = N2W'(sq_root);
            end
            for (int i = 0; i < 4; i++) begin
                if (sq_side.kind == qau_pkg::KIND_INV) begin
                    num = NW'(sq_side.mag[i]) << (2 * FB);
                end else begin
                    num = NW'(sq_side.mag[i]) << FB;
                end
                r4_num[i] <= (num << 1) + NW'(den);
            end
            r4_den  <= {den, 1'b0};
            r4_side <= sq_side;
        end
    end

    // divider
    logic               dv_vld;
    qau_pkg::t_side     dv_side;
    logic [3:0][CW-1:0] dv_quo;
    logic [3:0]         dv_ovf;

    qau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r4_vld),
        .i_side  (r4_side),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .o_vld   (dv_vld),
        .o_side  (dv_side),
        .o_quo   (dv_quo),
        .o_ovf   (dv_ovf)
    );

    // output register
    logic               r_out_vld;
    logic [3:0][CW-1:0] r_out_r, n_out_r;
    logic               r_out_test, n_out_test;
    logic [1:0]         r_out_status, n_out_status;

    always_comb begin
        logic          sat;
        logic          neg;
        logic [MW-1:0] mag;
        t_enc          e;
        n_out_r      = '0;
        n_out_test   = 1'b0;
        n_out_status = qau_pkg::STATUS_OK;
        sat          = 1'b0;
        neg          = 1'b0;
        mag          = '0;
        e            = '0;
        unique case (dv_side.kind)
            qau_pkg::KIND_MUL, qau_pkg::KIND_CONJ: begin
                n_out_r      = dv_side.res;
                n_out_status = dv_side.sat ? qau_pkg::STATUS_SAT : qau_pkg::STATUS_OK;
            end
            qau_pkg::KIND_INV, qau_pkg::KIND_NORM: begin
                if (dv_side.zero) begin
                    n_out_status = qau_pkg::STATUS_ZERO;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        if (dv_side.kind == qau_pkg::KIND_INV && i != 0) begin
                            neg = !dv_side.neg[i];
                        end else begin
                            neg = dv_side.neg[i];
                        end
                        mag = dv_ovf[i] ? {MW{1'b1}} : MW'(dv_quo[i]);
                        e   = f_encode(neg, mag);
                        n_out_r[i] = e.val;
                        sat        = sat | e.sat;
                    end
                    n_out_status = sat ? qau_pkg::STATUS_SAT : qau_pkg::STATUS_OK;
                end
            end
            qau_pkg::KIND_UNIT, qau_pkg::KIND_APPROX: begin
                n_out_test = dv_side.test;
            end
            default: ;
        endcase
    end

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld    <= 1'b0;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r0_vld    <= i_in_valid;
            r1_vld    <= r0_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= sq_vld;
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_r      <= n_out_r;
            r_out_test   <= n_out_test;
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_r_scalar  = r_out_r[0];
    assign o_r_x       = r_out_r[1];
    assign o_r_y       = r_out_r[2];
    assign o_r_z       = r_out_r[3];
    assign o_test_true = r_out_test;
    assign o_status    = r_out_status;

`ifndef SYNTH
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == qau_pkg::STATUS_ZERO |->
        o_r_scalar == '0 && o_r_x == '0 && o_r_y == '0 && o_r_z == '0 && !o_test_true)
        else $error("zero norm result with nonzero fields");

    a_test_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_test_true |-> o_status == qau_pkg::STATUS_OK)
        else $error("test result with error status");

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input held off without output stall");
`endif

endmodule
`default_nettype wire

// File: rtl/core/qau_sqrt.sv
`default_nettype none
module qau_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire qau_pkg::t_side             i_side,
    output logic                            o_vld,
    output qau_pkg::t_side                  o_side,
    output logic [qau_pkg::SQW-1:0]         o_root
);

    localparam int NS  = qau_pkg::SQ_STAGES;
    localparam int AW  = qau_pkg::N2W;
    localparam int RSW = qau_pkg::SRW;

    logic [AW-1:0]     r_a   [NS];
    logic [RSW-1:0]    r_res [NS];
    qau_pkg::t_side    r_side [NS];
    logic [NS-1:0]     r_vld;

    logic [AW-1:0]     n_a   [NS];
    logic [RSW-1:0]    n_res [NS];
    qau_pkg::t_side    n_side [NS];
    logic [NS-1:0]     n_vld;

    always_comb begin
        logic [AW-1:0]  p_a;
        logic [RSW-1:0] p_res;
        logic [RSW-1:0] bitv;
        logic [RSW-1:0] t;
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                p_a       = i_side.n2;
                p_res     = '0;
                n_side[s] = i_side;
                n_vld[s]  = i_vld;
            end else begin
                p_a       = r_a[s-1];
                p_res     = r_res[s-1];
                n_side[s] = r_side[s-1];
                n_vld[s]  = r_vld[s-1];
            end
            bitv = RSW'(1) << (2 * (NS - 1 - s));
            t    = p_res + bitv;
            if (RSW'(p_a) >= t) begin
                n_a[s]   = p_a - t[AW-1:0];
                n_res[s] = (p_res >> 1) + bitv;
            end else begin
                n_a[s]   = p_a;
                n_res[s] = p_res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NS; s++) begin
                r_a[s]    <= n_a[s];
                r_res[s]  <= n_res[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_side = r_side[NS-1];
    assign o_root = r_res[NS-1][qau_pkg::SQW-1:0];

endmodule
`default_nettype wire

// File: rtl/core/qau_div.sv
`default_nettype none
module qau_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_vld,
    input  wire qau_pkg::t_side                     i_side,
    input  wire logic [3:0][qau_pkg::NW-1:0]        i_num,
    input  wire logic [qau_pkg::DW-1:0]             i_den,
    output logic                                    o_vld,
    output qau_pkg::t_side                          o_side,
    output logic [3:0][qau_pkg::QW-1:0]             o_quo,
    output logic [3:0]                              o_ovf
);

    localparam int NS   = qau_pkg::QW + 1;
    localparam int QBW  = qau_pkg::QW;
    localparam int NUMW = qau_pkg::NW;
    localparam int DENW = qau_pkg::DW;
    localparam int REMW = qau_pkg::RW;

    logic [3:0][NUMW-1:0]  r_rem  [NS];
    logic [3:0][QBW-1:0]   r_q    [NS];
    logic [3:0]            r_ovf  [NS];
    logic [DENW-1:0]       r_den  [NS];
    qau_pkg::t_side        r_side [NS];
    logic [NS-1:0]         r_vld;

    logic [3:0][NUMW-1:0]  n_rem  [NS];
    logic [3:0][QBW-1:0]   n_q    [NS];
    logic [3:0]            n_ovf  [NS];
    logic [DENW-1:0]       n_den  [NS];
    qau_pkg::t_side        n_side [NS];
    logic [NS-1:0]         n_vld;

    always_comb begin
        logic [REMW-1:0] sh;
        logic [REMW-1:0] diff;
        sh   = '0;
        diff = '0;
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                n_den[s]  = i_den;
                n_side[s] = i_side;
                n_vld[s]  = i_vld;
                n_rem[s]  = i_num;
                n_q[s]    = '0;
                for (int l = 0; l < 4; l++) begin
                    n_ovf[s][l] = REMW'(i_num[l]) >= {i_den, {QBW{1'b0}}};
                end
            end else begin
                n_den[s]  = r_den[s-1];
                n_side[s] = r_side[s-1];
                n_vld[s]  = r_vld[s-1];
                n_ovf[s]  = r_ovf[s-1];
                sh        = REMW'(r_den[s-1]) << (NS - 1 - s);
                for (int l = 0; l < 4; l++) begin
                    diff = REMW'(r_rem[s-1][l]) - sh;
                    if (REMW'(r_rem[s-1][l]) >= sh) begin
                        n_rem[s][l] = diff[NUMW-1:0];
                        n_q[s][l]   = r_q[s-1][l] | (QBW'(1) << (NS - 1 - s));
                    end else begin
                        n_rem[s][l] = r_rem[s-1][l];
                        n_q[s][l]   = r_q[s-1][l];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NS; s++) begin
                r_rem[s]  <= n_rem[s];
                r_q[s]    <= n_q[s];
                r_ovf[s]  <= n_ovf[s];
                r_den[s]  <= n_den[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_side = r_side[NS-1];
    assign o_quo  = r_q[NS-1];
    assign o_ovf  = r_ovf[NS-1];

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int CW = qau_pkg::CW;
    localparam int FB = qau_pkg::FB;
    localparam int TW = qau_pkg::TW;

    typedef logic [CW-1:0] t_coef;

    typedef struct {
        logic [2:0] kind;
        t_coef      a[4];
        t_coef      b[4];
    } t_quat_op;

    typedef struct {
        t_coef      r[4];
        logic       test_true;
        logic [1:0] status;
    } t_quat_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [2:0] i_kind = '0;
    t_coef i_a_scalar = '0, i_a_x = '0, i_a_y = '0, i_a_z = '0;
    t_coef i_b_scalar = '0, i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_coef o_r_scalar, o_r_x, o_r_y, o_r_z;
    logic o_test_true;
    logic [1:0] o_status;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [TW-1:0] i_cfg_data = '0;

    t_quat_op  op_pending[$];
    t_quat_res res_expected[$];
    t_quat_op  cur_op;
    int errors = 0;
    bit calm = 1'b0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;

    logic [TW-1:0] unit_tol = TW'(268), approx_tol = TW'(268), min_norm = TW'(1);

    quaternion_arith_unit u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_coef sat_pack(bit neg, logic [159:0] mag, ref bit sat);
        if (!neg) begin
            if (mag >= 160'h8000_0000) begin
                sat = 1'b1;
                return 32'h7fff_ffff;
            end
            return mag[31:0];
        end
        if (mag > 160'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return -mag[31:0];
    endfunction

    function automatic logic [159:0] abs_coef(t_coef c);
        logic signed [CW:0] s;
        s = $signed({c[CW-1], c});
        return (s < 0) ? 160'(-s) : 160'(s);
    endfunction

    function automatic t_quat_res quat_predict(t_quat_op op);
        t_quat_res res;
        logic signed [69:0] sa[4], sb[4], acc[4];
        logic signed [CW:0] d;
        logic [159:0] n2, nd, root, t, mag, one, lo, hi;
        bit neg, sat;
        sat = 1'b0;
        res.test_true = 1'b0;
        res.status = qau_pkg::STATUS_OK;
        n2 = '0;
        nd = '0;
        for (int i = 0; i < 4; i++) begin
            res.r[i] = '0;
            sa[i] = $signed(op.a[i]);
            sb[i] = $signed(op.b[i]);
            n2 += abs_coef(op.a[i]) * abs_coef(op.a[i]);
            d = $signed({op.a[i][CW-1], op.a[i]}) - $signed({op.b[i][CW-1], op.b[i]});
            t = (d < 0) ? 160'(-d) : 160'(d);
            nd += t * t;
        end
        case (op.kind)
            qau_pkg::KIND_MUL: begin
                acc[0] = sa[0]*sb[0] - sa[1]*sb[1] - sa[2]*sb[2] - sa[3]*sb[3];
                acc[1] = sa[0]*sb[1] + sa[1]*sb[0] + sa[2]*sb[3] - sa[3]*sb[2];
                acc[2] = sa[0]*sb[2] - sa[1]*sb[3] + sa[2]*sb[0] + sa[3]*sb[1];
                acc[3] = sa[0]*sb[3] + sa[1]*sb[2] - sa[2]*sb[1] + sa[3]*sb[0];
                for (int i = 0; i < 4; i++) begin
                    neg = acc[i] < 0;
                    mag = neg ? 160'(-acc[i]) : 160'(acc[i]);
                    mag = (mag + (160'd1 << (FB - 1))) >> FB;
                    res.r[i] = sat_pack(neg, mag, sat);
                end
                res.status = sat ? qau_pkg::STATUS_SAT : qau_pkg::STATUS_OK;
            end
            qau_pkg::KIND_CONJ: begin
                for (int i = 0; i < 4; i++)
                    res.r[i] = sat_pack((i == 0) ? op.a[i][CW-1] : !op.a[i][CW-1],
                                        abs_coef(op.a[i]), sat);
                res.status = sat ? qau_pkg::STATUS_SAT : qau_pkg::STATUS_OK;
            end
            qau_pkg::KIND_INV, qau_pkg::KIND_NORM: begin
                if (n2 == 0 || n2 < 160'(min_norm) * 160'(min_norm)) begin
                    res.status = qau_pkg::STATUS_ZERO;
                end else begin
                    root = '0;
                    for (int k = 34; k >= 0; k--) begin
                        t = root | (160'd1 << k);
                        if (t * t <= n2) root = t;
                    end
                    for (int i = 0; i < 4; i++) begin
                        if (op.kind == qau_pkg::KIND_INV) begin
                            neg = (i == 0) ? op.a[i][CW-1] : !op.a[i][CW-1];
                            mag = ((abs_coef(op.a[i]) << (2*FB+1)) + n2) / (n2 << 1);
                        end else begin
                            neg = op.a[i][CW-1];
                            mag = ((abs_coef(op.a[i]) << (FB+1)) + root) / (root << 1);
                        end
                        res.r[i] = sat_pack(neg, mag, sat);
                    end
                    res.status = sat ? qau_pkg::STATUS_SAT : qau_pkg::STATUS_OK;
                end
            end
            qau_pkg::KIND_UNIT: begin
                one = 160'd1 << FB;
                hi = one + 160'(unit_tol);
                lo = (one > 160'(unit_tol)) ? one - 160'(unit_tol) : '0;
                res.test_true = (n2 >= lo * lo) && (n2 <= hi * hi);
            end
            qau_pkg::KIND_APPROX:
                res.test_true = nd <= 160'(approx_tol) * 160'(approx_tol);
            default: ;
        endcase
        return res;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        bit fire, next_valid;
        fire = i_in_valid && o_in_ready;
        next_valid = i_in_valid && !fire;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (fire) res_expected.push_back(quat_predict(cur_op));
            if (!next_valid && op_pending.size() > 0 &&
                (calm || $urandom_range(0, 99) >= 17)) begin
                cur_op = op_pending.pop_front();
                i_kind <= cur_op.kind;
                i_a_scalar <= cur_op.a[0];
                i_a_x <= cur_op.a[1];
                i_a_y <= cur_op.a[2];
                i_a_z <= cur_op.a[3];
                i_b_scalar <= cur_op.b[0];
                i_b_x <= cur_op.b[1];
                i_b_y <= cur_op.b[2];
                i_b_z <= cur_op.b[3];
                next_valid = 1'b1;
            end
        end
        i_in_valid <= next_valid;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_quat_res want;
        t_coef got[4];
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_r_scalar, o_r_x, o_r_y, o_r_z};
                if (res_expected.size() == 0) begin
                    $display("%0t unexpected result beat", $realtime);
                    errors++;
                end else begin
                    want = res_expected.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (got[i] !== want.r[i]) begin
                            $display("%0t r[%0d] expected %h actual %h",
                                     $realtime, i, want.r[i], got[i]);
                            errors++;
                        end
                    if (o_test_true !== want.test_true) begin
                        $display("%0t test_true expected %b actual %b",
                                 $realtime, want.test_true, o_test_true);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t status expected %0d actual %0d",
                                 $realtime, want.status, o_status);
                        errors++;
                    end
                end
            end
            if (hold_go && !hold_done) begin
                hold_done <= 1'b1;
                hold_cnt <= 300;
                i_out_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || $urandom_range(0, 99) >= 17;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [TW-1:0] val);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            qau_pkg::CFG_UNIT_TOL:   unit_tol = val;
            qau_pkg::CFG_APPROX_TOL: approx_tol = val;
            qau_pkg::CFG_MIN_NORM:   min_norm = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        forever begin
            @(negedge i_clk);
            if (op_pending.size() == 0 && !i_in_valid && res_expected.size() == 0) break;
        end
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_coef rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return t_coef'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
            2: return t_coef'($signed($urandom_range(0, 2000)) - 1000);
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return t_coef'($signed($urandom_range(0, 1 << 31)) - (1 << 30));
        endcase
    endfunction

    function automatic t_quat_op rand_op();
        t_quat_op op;
        int pick;
        pick = $urandom_range(0, 99);
        op.kind = (pick < 6) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        for (int i = 0; i < 4; i++) begin
            op.a[i] = rand_coef();
            op.b[i] = rand_coef();
        end
        if (op.kind == qau_pkg::KIND_UNIT && $urandom_range(0, 1)) begin
            op.a = '{32'h1000_0000, 0, 0, 0};
            op.a[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 32'h1000_0000 : 32'hf000_0000;
            op.a[$urandom_range(0, 3)] += t_coef'($signed($urandom_range(0, 600)) - 300);
        end
        if (op.kind == qau_pkg::KIND_APPROX && $urandom_range(0, 1))
            for (int i = 0; i < 4; i++)
                op.b[i] = op.a[i] + t_coef'($signed($urandom_range(0, 400)) - 200);
        return op;
    endfunction

    function automatic t_quat_op mk_op(logic [2:0] k, t_coef a0, t_coef a1, t_coef a2,
                                       t_coef a3, t_coef b0);
        t_quat_op op;
        op.kind = k;
        op.a = '{a0, a1, a2, a3};
        op.b = '{b0, b0, b0, b0};
        return op;
    endfunction

    localparam t_coef QMAX = 32'h7fff_ffff;
    localparam t_coef QMIN = 32'h8000_0000;
    localparam t_coef QONE = 32'h1000_0000;

    initial begin
        logic [TW-1:0] cfg_set[5][3];
        cfg_set = '{'{TW'(268), TW'(268), TW'(1)}, '{TW'(0), TW'(0), TW'(0)},
                    '{31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff},
                    '{TW'(1 << 20), TW'(1 << 24), TW'(1 << 26)},
                    '{TW'(0), TW'(0), TW'(0)}};
        for (int k = 0; k < 3; k++) cfg_set[4][k] = TW'($urandom_range(0, 1 << 29));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats at reset settings
        op_pending.push_back(mk_op(qau_pkg::KIND_MUL, QMAX, QMAX, QMAX, QMAX, QMAX));
        op_pending.push_back(mk_op(qau_pkg::KIND_MUL, QMIN, QMIN, QMIN, QMIN, QMIN));
        op_pending.push_back(mk_op(qau_pkg::KIND_MUL, QONE, 0, 0, 0, QMIN));
        op_pending.push_back(mk_op(qau_pkg::KIND_MUL, 0, 0, 0, 0, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_CONJ, QMIN, QMIN, QMAX, 0, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_CONJ, QMAX, 1, -1, QMAX, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_INV, 0, 0, 0, 0, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_INV, 1, 0, 0, 0, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_INV, QONE, QONE, -QONE, QONE, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_INV, QMIN, QMIN, QMIN, QMIN, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_NORM, 0, 0, 0, 0, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_NORM, 1, 0, 0, 0, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_NORM, QMAX, QMIN, QMAX, QMIN, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_UNIT, QONE, 0, 0, 0, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_UNIT, QONE + 268, 0, 0, 0, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_UNIT, QONE + 269, 0, 0, 0, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_UNIT, QMAX, QMAX, QMAX, QMAX, 0));
        op_pending.push_back(mk_op(qau_pkg::KIND_APPROX, QONE, 0, 0, 0, QONE));
        op_pending.push_back(mk_op(qau_pkg::KIND_APPROX, QONE, QONE, QONE, QONE, -QONE));
        op_pending.push_back(mk_op(qau_pkg::KIND_APPROX, QMAX, QMAX, QMAX, QMAX, QMIN));
        op_pending.push_back(mk_op(3'd6, QMAX, QMAX, QMAX, QMAX, QMAX));
        op_pending.push_back(mk_op(3'd7, QMIN, QMIN, QMIN, QMIN, QMIN));
        drain();
        write_reg(2'd3, 31'h7fff_ffff);

        for (int ph = 0; ph < 5; ph++) begin
            for (int k = 0; k < 3; k++) write_reg(2'(k), cfg_set[ph][k]);
            calm = (ph == 1);
            for (int n = 0; n < 100; n++) op_pending.push_back(rand_op());
            if (ph == 2) begin
                wait (op_pending.size() < 90);
                hold_go = 1'b1;
            end
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
